// ===== rtl/drid_pkg.sv =====
// Shared types, codes and helpers for the delta row index decoder.
`timescale 1ns / 1ps

package drid_pkg;

  localparam int unsigned KeyW = 63;
  localparam int unsigned AccW = 64;
  localparam int unsigned ElemW = 31;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_END    = 2'd2,
    KIND_BAD    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_CMD   = 2'd0,
    PH_VALUE = 2'd1,
    PH_ELEM  = 2'd2
  } phase_e;

  // Command field, bits 6:3 of a command byte.
  localparam logic [3:0] CMD_OFFSET = 4'd1;
  localparam logic [3:0] CMD_SHORTS = 4'd2;
  localparam logic [3:0] CMD_BYTES  = 4'd3;
  localparam logic [3:0] CMD_END    = 4'd4;

  // Width codes, bits 2:0 of a command byte.
  localparam logic [2:0] WID_2B = 3'd1;
  localparam logic [2:0] WID_4B = 3'd2;
  localparam logic [2:0] WID_8B = 3'd3;
  localparam logic [2:0] WID_1B = 3'd4;

  typedef struct packed {
    kind_e             kind;
    logic [KeyW-1:0]   first_key;
    logic [KeyW-1:0]   last_key;
    logic              is_last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [3:0] value_bytes(input logic [2:0] code);
    logic [3:0] len;
    unique case (code)
      WID_2B:  len = 4'd2;
      WID_4B:  len = 4'd4;
      WID_8B:  len = 4'd8;
      WID_1B:  len = 4'd1;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic result_t mk_result(input kind_e kind, input logic [KeyW-1:0] first,
                                        input logic [KeyW-1:0] last);
    result_t r;
    r.kind      = kind;
    r.first_key = first;
    r.last_key  = last;
    r.is_last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/drid_if.sv =====
// Stream channel interfaces: encoded byte input and decoded result output.
`timescale 1ns / 1ps

interface drid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface drid_out_if;
  import drid_pkg::*;
  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [KeyW-1:0]  first_key;
  logic [KeyW-1:0]  last_key;
  logic             is_last;

  modport source (output valid, output kind, output first_key, output last_key,
                  output is_last, input ready);
  modport sink (input valid, input kind, input first_key, input last_key,
                input is_last, output ready);
endinterface

// ===== rtl/drid_decode.sv =====
// Byte register, decoder state and single-pass command/value decode.
`timescale 1ns / 1ps

module drid_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  output logic            in_ready_o,
  input  logic            room_i,
  output drid_pkg::push_t push_o
);
  import drid_pkg::*;

  typedef struct packed {
    phase_e            phase;
    logic [1:0]        ckind;
    logic [2:0]        wcode;
    logic [AccW-1:0]   acc;
    logic [3:0]        bleft;
    logic [ElemW-1:0]  eleft;
    logic [AccW-1:0]   roff;
    logic [KeyW-1:0]   pkey;
    logic              pvld;
  } st_t;

  function automatic st_t clear_st();
    st_t s;
    s.phase = PH_CMD;
    s.ckind = '0;
    s.wcode = '0;
    s.acc   = '0;
    s.bleft = '0;
    s.eleft = '0;
    s.roff  = '0;
    s.pkey  = '0;
    s.pvld  = 1'b0;
    return s;
  endfunction

  logic [7:0]       byte_q;
  logic             bvld_q;
  st_t              st_q, st_d;
  logic             advance;
  logic [AccW-1:0]  acc_sh;
  logic [3:0]       bl_dec;
  logic [3:0]       len;
  logic [AccW-1:0]  val;
  logic             neg;
  logic [AccW-1:0]  sum;
  logic [KeyW-1:0]  key;
  logic [3:0]       cmd;
  logic [ElemW-1:0] el_dec;
  result_t          r0, r1;
  logic [1:0]       n;

  assign advance    = bvld_q && room_i;
  assign in_ready_o = !bvld_q || advance;

  assign acc_sh = {byte_q, st_q.acc[AccW-1:8]};
  assign bl_dec = (st_q.bleft != 4'd0) ? st_q.bleft - 4'd1 : 4'd0;
  assign cmd    = byte_q[6:3];
  assign el_dec = st_q.eleft - ElemW'(1);

  always_comb begin
    if (st_q.phase == PH_VALUE) begin
      len = value_bytes(st_q.wcode);
    end else begin
      len = (st_q.ckind == CMD_SHORTS[1:0]) ? 4'd2 : 4'd1;
    end
  end

  always_comb begin
    case (len)
      4'd2:    val = {{48{acc_sh[63]}}, acc_sh[63:48]};
      4'd4:    val = {{32{acc_sh[63]}}, acc_sh[63:32]};
      4'd8:    val = acc_sh;
      default: val = {{56{acc_sh[63]}}, acc_sh[63:56]};
    endcase
  end

  // Magnitude add: two's complement negate folded into the carry-in.
  assign neg = val[AccW-1];
  assign sum = st_q.roff + (val ^ {AccW{neg}}) + {{(AccW-1){1'b0}}, neg};
  assign key = sum[KeyW-1:0];

  always_comb begin
    st_d = st_q;
    r0   = mk_result(KIND_SINGLE, '0, '0);
    r1   = mk_result(KIND_SINGLE, '0, '0);
    n    = 2'd0;
    unique case (st_q.phase)
      PH_CMD: begin
        if (cmd == CMD_END) begin
          if (st_q.pvld) begin
            r0 = mk_result(KIND_SINGLE, st_q.pkey, st_q.pkey);
            r1 = mk_result(KIND_END, '0, '0);
            n  = 2'd2;
          end else begin
            r0 = mk_result(KIND_END, '0, '0);
            n  = 2'd1;
          end
          st_d = clear_st();
        end else if ((cmd == CMD_OFFSET || cmd == CMD_SHORTS || cmd == CMD_BYTES) &&
                     value_bytes(byte_q[2:0]) != 4'd0) begin
          st_d.ckind = cmd[1:0];
          st_d.wcode = byte_q[2:0];
          st_d.bleft = value_bytes(byte_q[2:0]);
          st_d.acc   = '0;
          st_d.phase = PH_VALUE;
        end else begin
          st_d = clear_st();
          r0   = mk_result(KIND_BAD, '0, '0);
          n    = 2'd1;
        end
      end
      PH_VALUE, PH_ELEM: begin
        st_d.acc   = acc_sh;
        st_d.bleft = bl_dec;
        if (bl_dec == 4'd0) begin
          st_d.acc = '0;
          if (st_q.phase == PH_VALUE && st_q.ckind != CMD_OFFSET[1:0]) begin
            if (val[31] || val[30:0] == '0) begin
              st_d.eleft = '0;
              st_d.phase = PH_CMD;
            end else begin
              st_d.eleft = val[ElemW-1:0];
              st_d.phase = PH_ELEM;
              st_d.bleft = (st_q.ckind == CMD_SHORTS[1:0]) ? 4'd2 : 4'd1;
            end
          end else begin
            if (st_q.phase == PH_ELEM) begin
              st_d.eleft = el_dec;
              if (el_dec != '0) begin
                st_d.bleft = (st_q.ckind == CMD_SHORTS[1:0]) ? 4'd2 : 4'd1;
              end else begin
                st_d.phase = PH_CMD;
              end
            end else begin
              st_d.phase = PH_CMD;
            end
            st_d.roff = sum;
            if (!st_q.pvld) begin
              if (neg) begin
                st_d = clear_st();
                r0   = mk_result(KIND_BAD, '0, '0);
                n    = 2'd1;
              end else begin
                st_d.pkey = key;
                st_d.pvld = 1'b1;
              end
            end else if (neg) begin
              r0        = mk_result(KIND_RANGE, st_q.pkey, key);
              n         = 2'd1;
              st_d.pvld = 1'b0;
              st_d.pkey = '0;
            end else begin
              r0        = mk_result(KIND_SINGLE, st_q.pkey, st_q.pkey);
              n         = 2'd1;
              st_d.pkey = key;
            end
          end
        end
      end
      default: begin
        st_d = clear_st();
      end
    endcase
    if (n == 2'd2) begin
      r1.is_last = 1'b1;
    end else begin
      r0.is_last = 1'b1;
    end
  end

  always_comb begin
    push_o.cnt = advance ? n : 2'd0;
    push_o.r0  = r0;
    push_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q <= 1'b0;
      st_q   <= clear_st();
    end else begin
      if (in_valid_i && in_ready_o) begin
        bvld_q <= 1'b1;
      end else if (advance) begin
        bvld_q <= 1'b0;
      end
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

`ifndef ASSERT_OFF
  a_two_is_flush_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> push_o.r0.kind == KIND_SINGLE && push_o.r1.kind == KIND_END)
    else $error("two results must be a pending flush followed by end");
  a_push_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt != 2'd0 |-> bvld_q && room_i)
    else $error("results pushed without a held byte or queue room");
  a_bad_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && push_o.cnt != 2'd0 && push_o.r0.kind == KIND_BAD
    |=> st_q.phase == PH_CMD && !st_q.pvld && st_q.roff == '0)
    else $error("bad stream did not clear decoder state");
`endif

endmodule

// ===== rtl/drid_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle while it holds at most two.
`timescale 1ns / 1ps

module drid_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drid_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output drid_pkg::result_t out_data_o
);
  import drid_pkg::*;

  result_t    mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = cnt_q != 3'd0;
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = cnt_q <= 3'd2;
  assign cnt_d       = cnt_q + {1'b0, push_i.cnt} - {2'b00, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.cnt;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.r1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> cnt_q <= 3'd2)
    else $error("result pushed into a full queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4 && push_i.cnt != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// ===== rtl/delta_row_index_decoder_top.sv =====
// Top level of the delta row index decoder.
`timescale 1ns / 1ps

// Takes one encoded byte per cycle while the queue has room, and emits single
// keys, inclusive ranges, end markers and bad-stream results, one result per
// output transfer. A byte is held in an input register, decoded against the
// running offset and pending key, and its results go into a four-entry queue
// that drives the output, so a result is offered once its byte has passed the
// input register and been written into the queue. The input keeps taking a
// byte every cycle while the queue holds at most two results; the only byte
// that yields two results is an end command with a key pending, which needs
// two output transfers.
module delta_row_index_decoder_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  drid_in_if.sink   in_i,
  drid_out_if.source out_o
);
  import drid_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  drid_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_ready_o (in_i.ready),
    .room_i     (room),
    .push_o     (push)
  );

  drid_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (head)
  );

  assign out_o.kind      = head.kind;
  assign out_o.first_key = head.first_key;
  assign out_o.last_key  = head.last_key;
  assign out_o.is_last   = head.is_last;

endmodule

// ===== test/tb_delta_row_index_decoder_top.sv =====
// Self-checking testbench: directed and random encoded streams, predicted results checked in order.
`timescale 1ns / 1ps

module tb_delta_row_index_decoder_top;
  import drid_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 16;

  logic clk_i;
  logic rst_ni;

  drid_in_if  in_if();
  drid_out_if out_if();

  delta_row_index_decoder_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Decoder state as predicted from the accepted byte stream.
  phase_e          dec_phase;
  logic [3:0]      dec_cmd;
  logic [2:0]      dec_wc;
  logic [AccW-1:0] dec_asm;
  logic [3:0]      dec_left;
  logic [ElemW-1:0] dec_elems;
  logic [AccW-1:0] dec_offset;
  logic [KeyW-1:0] dec_pend_key;
  logic            dec_pend_vld;

  result_t     decoded_q[$];
  int          n_errors;
  int          bytes_sent;
  int          src_idle_pct;
  int          snk_stall_pct;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL delta_row_index_decoder_top");
      $finish;
    end
  end

  function automatic int width_len(input logic [2:0] code);
    case (code)
      WID_1B:  return 1;
      WID_2B:  return 2;
      WID_4B:  return 4;
      WID_8B:  return 8;
      default: return 0;
    endcase
  endfunction

  function automatic int elem_len();
    return (dec_cmd == CMD_SHORTS) ? 2 : 1;
  endfunction

  function automatic result_t key_result(input kind_e k, input logic [KeyW-1:0] f,
                                         input logic [KeyW-1:0] l);
    result_t r;
    r.kind      = k;
    r.first_key = f;
    r.last_key  = l;
    r.is_last   = 1'b0;
    return r;
  endfunction

  task automatic clear_decoder();
    dec_phase    = PH_CMD;
    dec_cmd      = '0;
    dec_wc       = '0;
    dec_asm      = '0;
    dec_left     = '0;
    dec_elems    = '0;
    dec_offset   = '0;
    dec_pend_key = '0;
    dec_pend_vld = 1'b0;
  endtask

  task automatic apply_delta(input logic [AccW-1:0] v, ref result_t res[$]);
    logic [AccW-1:0] mag;
    logic [KeyW-1:0] key;
    mag        = v[63] ? (64'd0 - v) : v;
    dec_offset = dec_offset + mag;
    key        = dec_offset[KeyW-1:0];
    if (!dec_pend_vld) begin
      if (v[63]) begin
        clear_decoder();
        res.push_back(key_result(KIND_BAD, '0, '0));
      end else begin
        dec_pend_key = key;
        dec_pend_vld = 1'b1;
      end
    end else if (v[63]) begin
      res.push_back(key_result(KIND_RANGE, dec_pend_key, key));
      dec_pend_vld = 1'b0;
      dec_pend_key = '0;
    end else begin
      res.push_back(key_result(KIND_SINGLE, dec_pend_key, dec_pend_key));
      dec_pend_key = key;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    result_t            res[$];
    logic [3:0]         cmd;
    int                 len;
    logic signed [63:0] asm_s;
    logic [AccW-1:0]    v;
    logic [31:0]        cnt;
    if (dec_phase == PH_CMD) begin
      cmd = b[6:3];
      if (cmd == CMD_END) begin
        if (dec_pend_vld) res.push_back(key_result(KIND_SINGLE, dec_pend_key, dec_pend_key));
        res.push_back(key_result(KIND_END, '0, '0));
        clear_decoder();
      end else if ((cmd == CMD_OFFSET || cmd == CMD_SHORTS || cmd == CMD_BYTES) &&
                   width_len(b[2:0]) != 0) begin
        dec_cmd   = cmd;
        dec_wc    = b[2:0];
        dec_left  = 4'(width_len(b[2:0]));
        dec_asm   = '0;
        dec_phase = PH_VALUE;
      end else begin
        clear_decoder();
        res.push_back(key_result(KIND_BAD, '0, '0));
      end
    end else begin
      dec_asm = {b, dec_asm[63:8]};
      if (dec_left != 0) dec_left--;
      if (dec_left == 0) begin
        len     = (dec_phase == PH_VALUE) ? width_len(dec_wc) : elem_len();
        asm_s   = dec_asm;
        v       = asm_s >>> (64 - 8 * len);
        dec_asm = '0;
        if (dec_phase == PH_VALUE && dec_cmd != CMD_OFFSET) begin
          cnt = v[31:0];
          if (cnt[31]) cnt = '0;
          dec_elems = cnt[ElemW-1:0];
          if (cnt == 0) begin
            dec_phase = PH_CMD;
          end else begin
            dec_phase = PH_ELEM;
            dec_left  = 4'(elem_len());
          end
        end else begin
          if (dec_phase == PH_ELEM) begin
            dec_elems = dec_elems - 1'b1;
            if (dec_elems != 0) dec_left = 4'(elem_len());
            else dec_phase = PH_CMD;
          end else begin
            dec_phase = PH_CMD;
          end
          apply_delta(v, res);
        end
      end
    end
    if (res.size() != 0) res[res.size() - 1].is_last = 1'b1;
    foreach (res[i]) decoded_q.push_back(res[i]);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (out_if.valid && out_if.ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: kind %0d first_key %0h last_key %0h",
               out_if.kind, out_if.first_key, out_if.last_key);
        n_errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
          n_errors++;
        end
        if (out_if.first_key !== want.first_key) begin
          $error("first_key: expected %0h, got %0h", want.first_key, out_if.first_key);
          n_errors++;
        end
        if (out_if.last_key !== want.last_key) begin
          $error("last_key: expected %0h, got %0h", want.last_key, out_if.last_key);
          n_errors++;
        end
        if (out_if.is_last !== want.is_last) begin
          $error("is_last: expected %0b, got %0b", want.is_last, out_if.is_last);
          n_errors++;
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
    decode_byte(b);
  endtask

  task automatic send_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) send_byte(v[8*i +: 8]);
  endtask

  function automatic logic [7:0] cmd_byte(input logic [3:0] cmd, input logic [2:0] wc);
    return {1'($urandom_range(1)), cmd, wc};
  endfunction

  task automatic send_offset(input logic [2:0] wc, input logic [63:0] v);
    send_byte(cmd_byte(CMD_OFFSET, wc));
    send_le(v, width_len(wc));
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_offsets_and_ranges();
    send_offset(WID_1B, 64'h05);
    send_offset(WID_2B, 64'h7FFF);
    send_offset(WID_4B, 64'hFFFF_FFFF);
    send_offset(WID_8B, 64'h0);
    send_byte({1'b1, CMD_END, 3'b111});
    send_byte(cmd_byte(CMD_END, WID_1B));
    wait_drain();
  endtask

  task automatic test_bad_codes();
    send_offset(WID_1B, 64'h80);
    for (int w = 0; w < 8; w++) begin
      if (width_len(3'(w)) == 0) send_byte(cmd_byte(4'($urandom_range(3, 1)), 3'(w)));
    end
    for (int c = 0; c < 16; c++) begin
      if (!(4'(c) inside {CMD_OFFSET, CMD_SHORTS, CMD_BYTES, CMD_END}))
        send_byte(cmd_byte(4'(c), WID_1B));
    end
  endtask

  task automatic test_arrays();
    send_byte(cmd_byte(CMD_SHORTS, WID_2B));
    send_le(64'd3, 2);
    send_le(64'h0001, 2);
    send_le(64'h8000, 2);
    send_le(64'h7FFF, 2);
    send_byte(cmd_byte(CMD_BYTES, WID_1B));
    send_le(64'd4, 1);
    send_le(64'hFF00_807F, 4);
    send_byte(cmd_byte(CMD_BYTES, WID_4B));
    send_le(64'd0, 4);
    send_byte(cmd_byte(CMD_SHORTS, WID_8B));
    send_le(64'h1234_5678_8000_0000, 8);
    send_byte(cmd_byte(CMD_BYTES, WID_8B));
    send_le(64'hFFFF_FFFF_0000_0002, 8);
    send_le(64'h0201, 2);
    send_byte(cmd_byte(CMD_END, WID_2B));
  endtask

  task automatic test_wraparound();
    send_offset(WID_1B, 64'h01);
    send_offset(WID_8B, 64'h8000_0000_0000_0000);
    send_offset(WID_8B, 64'h7FFF_FFFF_FFFF_FFFF);
    send_offset(WID_8B, 64'h7FFF_FFFF_FFFF_FFFF);
    send_offset(WID_1B, 64'hFE);
    send_byte(cmd_byte(CMD_END, WID_4B));
    wait_drain();
  endtask

  function automatic logic [63:0] rand_delta();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return 64'($urandom_range(20));
    if (sel < 80) return 64'd0 - 64'($urandom_range(20, 1));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [2:0] rand_width();
    case ($urandom_range(3))
      0:       return WID_1B;
      1:       return WID_2B;
      2:       return WID_4B;
      default: return WID_8B;
    endcase
  endfunction

  // Build one complete command with its value and elements; hdr counts the
  // bytes before the first element.
  task automatic make_record(input logic [3:0] cmd, output int hdr, ref logic [7:0] rec[$]);
    logic [2:0]  wc;
    logic [63:0] val;
    int          len;
    int          n_el;
    wc  = rand_width();
    len = width_len(wc);
    rec.push_back(cmd_byte(cmd, wc));
    hdr = 1;
    val = rand_delta();
    if (cmd != CMD_OFFSET) begin
      if ($urandom_range(99) < 10) n_el = -int'($urandom_range(100, 1));
      else n_el = $urandom_range(6);
      val = 64'(n_el);
      if (wc == WID_8B) val[63:32] = $urandom;
      hdr = 1 + len;
    end
    for (int i = 0; i < len; i++) rec.push_back(val[8*i +: 8]);
    if (cmd != CMD_OFFSET) begin
      for (int e = 0; e < n_el; e++) begin
        val = rand_delta();
        rec.push_back(val[7:0]);
        if (cmd == CMD_SHORTS) rec.push_back(val[15:8]);
      end
    end
  endtask

  // Finish a broken command with bytes that keep element counts small.
  task automatic resync();
    while (dec_phase != PH_CMD) begin
      if (dec_phase == PH_VALUE && dec_cmd != CMD_OFFSET)
        send_byte((dec_left == 4'(width_len(dec_wc))) ? 8'($urandom_range(3)) : 8'h00);
      else
        send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_stream(input int n_bytes, input int idle_pct, input int stall_pct);
    logic [7:0]  rec[$];
    logic [3:0]  cmd;
    int          hdr;
    int          keep;
    int          start;
    int unsigned sel;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    start         = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      resync();
      rec.delete();
      sel = $urandom_range(99);
      if (sel < 75 || sel >= 90) begin
        if (sel < 40 || sel >= 95) cmd = CMD_OFFSET;
        else if (sel < 60 || sel >= 93) cmd = CMD_SHORTS;
        else cmd = CMD_BYTES;
        make_record(cmd, hdr, rec);
        keep = rec.size();
        if (sel >= 90 && keep - 1 >= hdr) keep = $urandom_range(keep - 1, hdr);
        for (int i = 0; i < keep; i++) send_byte(rec[i]);
      end else if (sel < 82) begin
        send_byte(cmd_byte(CMD_END, 3'($urandom_range(7))));
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
    wait_drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    out_if.ready  = 1'b0;
    n_errors      = 0;
    bytes_sent    = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    cycles        = 0;
    clear_decoder();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_offsets_and_ranges();
    test_bad_codes();
    test_arrays();
    test_wraparound();
    test_random_stream(450, 0, 0);
    test_random_stream(450, 87, 0);
    test_random_stream(450, 0, 87);
    test_random_stream(450, 16, 16);

    repeat (DrainCycles) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("PASS delta_row_index_decoder_top");
    end else begin
      $display("FAIL delta_row_index_decoder_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/drid_pkg.sv
rtl/drid_if.sv
rtl/drid_decode.sv
rtl/drid_fifo.sv
rtl/delta_row_index_decoder_top.sv
test/tb_delta_row_index_decoder_top.sv
